// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, sampled on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/pcgbg_pkg.sv -----
// ----------------------------------------------------------------------------
// pcgbg_pkg
// constants, types and the xsh-rr output function of the bounded generator
// ----------------------------------------------------------------------------
package pcgbg_pkg;

   localparam int unsigned StateWidth = 64;
   localparam int unsigned WordWidth  = 32;
   localparam int unsigned CsrIdxWidth = 2;

   localparam logic [StateWidth-1:0] PcgMult   = 64'h5851_F42D_4C95_7F2D;
   localparam logic [StateWidth-1:0] SeedReset = 64'h853C_49E6_748F_EA9B;
   localparam logic [StateWidth-1:0] IncrReset = 64'hDA3E_39CB_94B9_5BDB;

   localparam int unsigned XsShiftA = 18;
   localparam int unsigned XsShiftB = 27;
   localparam int unsigned RotShift = 59;

   localparam logic [CsrIdxWidth-1:0] CSR_SEED = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_INCR = 2'd1;

   typedef struct packed {
      logic                 start;
      logic [WordWidth-1:0] dividend;
      logic [WordWidth-1:0] divisor;
   } mod_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [WordWidth-1:0] remainder;
   } mod_rsp_type;

   function automatic logic [WordWidth-1:0] xsh_rr(input logic [StateWidth-1:0] s);
      logic [StateWidth-1:0]  mixed;
      logic [WordWidth-1:0]   x;
      logic [4:0]             r;
      logic [2*WordWidth-1:0] dbl;
      mixed = ((s >> XsShiftA) ^ s) >> XsShiftB;
      x     = mixed[WordWidth-1:0];
      r     = s[StateWidth-1:RotShift];
      dbl   = {x, x} >> r;
      return dbl[WordWidth-1:0];
   endfunction

endpackage

// ----- sv/pcgbg_serial_mod.sv -----
// ----------------------------------------------------------------------------
// pcgbg_serial_mod
// bit-serial restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module pcgbg_serial_mod
   import pcgbg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mod_req_type mod_req,
   output mod_rsp_type mod_rsp
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [4:0]           cnt_ff;
   logic [WordWidth-1:0] dvd_ff;
   logic [WordWidth-1:0] dsr_ff;
   logic [WordWidth-1:0] rem_ff;
   logic [WordWidth:0]   trial;
   logic [WordWidth:0]   diff;
   logic [WordWidth-1:0] rem_in;

   always_comb begin
      trial  = {rem_ff, dvd_ff[WordWidth-1]};
      diff   = trial - {1'b0, dsr_ff};
      rem_in = diff[WordWidth] ? trial[WordWidth-1:0] : diff[WordWidth-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && !mod_req.start && (cnt_ff == 5'(WordWidth - 1));
         if (mod_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            dvd_ff  <= mod_req.dividend;
            dsr_ff  <= mod_req.divisor;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            dvd_ff <= {dvd_ff[WordWidth-2:0], 1'b0};
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'(WordWidth - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign mod_rsp.busy      = busy_ff;
   assign mod_rsp.done      = done_ff;
   assign mod_rsp.remainder = rem_ff;

endmodule

// ----- sv/pcg32_bounded_generator.sv -----
// ----------------------------------------------------------------------------
// pcg32_bounded_generator
// pcg32 xsh-rr generator returning uniform words below a requested bound
// ----------------------------------------------------------------------------
// usage:
//   req channel carries upper_bound; one rsp word carries random_value.
//   csr channel writes seed_state (index 0, reloads the generator at once)
//   or stream_increment (index 1); other indexes are ignored. csr_ready is
//   always high; write only while no request is in flight.
//   a nonzero bound raises rsp_valid after a bit-serial lcg multiply
//   runs alongside the threshold remainder, then a second remainder
//   reduces the draw. each rejected draw adds another multiply. a zero
//   bound answers 0 via the push state without advancing the state.
//   one request is worked at a time; a finished word sits in the output
//   register and the next request is accepted while rsp stalls.
//   reset loads the lcg state from the seed reset value and empties the
//   output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcg32_bounded_generator
   import pcgbg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [WordWidth-1:0]   req_upper_bound,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [WordWidth-1:0]   rsp_random_value,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [StateWidth-1:0]  csr_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_THRESH,
      S_DRAW,
      S_MOD,
      S_PUSH
   } state_type;

   state_type             state_ff;
   logic [StateWidth-1:0] lcg_state_ff;
   logic [StateWidth-1:0] incr_ff;
   logic [WordWidth-1:0]  bound_ff;
   logic [WordWidth-1:0]  thresh_ff;
   logic [WordWidth-1:0]  draw_ff;
   logic [WordWidth-1:0]  result_ff;
   logic                  rsp_valid_ff;
   logic [WordWidth-1:0]  rsp_value_ff;
   mod_req_type           mod_req_ff;
   mod_rsp_type           mod_rsp;

   logic                  mul_busy_ff;
   logic                  mul_done_ff;
   logic [5:0]            mul_cnt_ff;
   logic [StateWidth-1:0] mcand_ff;
   logic [StateWidth-1:0] acc_ff;
   logic [StateWidth-1:0] acc_in;

   logic                  req_fire;
   logic                  csr_fire;
   logic                  draw_ok;
   logic                  mul_start;
   logic [StateWidth-1:0] mul_seed;
   logic                  out_free;
   logic                  mod_start_in;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign draw_ok   = (draw_ff >= thresh_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign mul_start = (req_fire && (req_upper_bound != '0))
                    || ((state_ff == S_DRAW) && mul_done_ff && !draw_ok);
   assign mul_seed  = (state_ff == S_IDLE) ? lcg_state_ff : acc_ff;
   assign acc_in    = acc_ff + (PcgMult[mul_cnt_ff] ? mcand_ff : '0);

   assign mod_start_in = (req_fire && (req_upper_bound != '0))
                       || ((state_ff == S_DRAW) && mul_done_ff && draw_ok);

   pcgbg_serial_mod u_mod (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req_ff),
      .mod_rsp (mod_rsp)
   );

   // lcg multiply, one multiplier bit per cycle, increment preloaded
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_busy_ff <= 1'b0;
         mul_done_ff <= 1'b0;
         mul_cnt_ff  <= '0;
      end else if (mul_start) begin
         mul_busy_ff <= 1'b1;
         mul_done_ff <= 1'b0;
         mul_cnt_ff  <= '0;
         mcand_ff    <= mul_seed;
         acc_ff      <= incr_ff | 64'd1;
      end else if (mul_busy_ff) begin
         acc_ff     <= acc_in;
         mcand_ff   <= {mcand_ff[StateWidth-2:0], 1'b0};
         mul_cnt_ff <= mul_cnt_ff + 6'd1;
         if (mul_cnt_ff == 6'(StateWidth - 1)) begin
            mul_busy_ff <= 1'b0;
            mul_done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         incr_ff <= IncrReset;
      end else if (csr_fire && (csr_index == CSR_INCR)) begin
         incr_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         lcg_state_ff     <= SeedReset;
         rsp_valid_ff     <= 1'b0;
         mod_req_ff.start <= 1'b0;
      end else begin
         mod_req_ff.start <= mod_start_in;
         if ((state_ff == S_PUSH) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  bound_ff <= req_upper_bound;
                  if (req_upper_bound == '0) begin
                     result_ff <= '0;
                     state_ff  <= S_PUSH;
                  end else begin
                     draw_ff             <= xsh_rr(lcg_state_ff);
                     mod_req_ff.dividend <= '0 - req_upper_bound;
                     mod_req_ff.divisor  <= req_upper_bound;
                     state_ff            <= S_THRESH;
                  end
               end
            end
            S_THRESH: begin
               if (mod_rsp.done) begin
                  thresh_ff <= mod_rsp.remainder;
                  state_ff  <= S_DRAW;
               end
            end
            S_DRAW: begin
               if (mul_done_ff) begin
                  lcg_state_ff <= acc_ff;
                  if (draw_ok) begin
                     mod_req_ff.dividend <= draw_ff;
                     mod_req_ff.divisor  <= bound_ff;
                     state_ff            <= S_MOD;
                  end else begin
                     draw_ff <= xsh_rr(acc_ff);
                  end
               end
            end
            S_MOD: begin
               if (mod_rsp.done) begin
                  result_ff <= mod_rsp.remainder;
                  state_ff  <= S_PUSH;
               end
            end
            S_PUSH: begin
               if (out_free) begin
                  rsp_value_ff <= result_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
         // seed write reloads the generator
         if (csr_fire && (csr_index == CSR_SEED)) begin
            lcg_state_ff <= csr_data;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = rsp_value_ff;

   `ASSERT_IMPL(a_rem_below_bound, (state_ff == S_MOD) && mod_rsp.done, mod_rsp.remainder < bound_ff, "remainder not below bound")

   `ASSERT_IMPL(a_div_idle_in_draw, state_ff == S_DRAW, !mod_rsp.busy, "divider busy while drawing")

   `ASSERT_NEXT(a_state_hold, !reset && (state_ff != S_DRAW) && !(csr_fire && (csr_index == CSR_SEED)), $stable(lcg_state_ff), "lcg state changed outside a draw")

endmodule
